// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int unsigned DEF_MAX_COLS = 80;
  localparam int unsigned DEF_MAX_ROWS = 25;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned IN_RROW_LSB = CHAR_W;
  localparam int unsigned IN_RCOL_LSB = CHAR_W + ROW_W;

  localparam int unsigned OUT_COL_LSB = CHAR_W;
  localparam int unsigned OUT_ROW_LSB = CHAR_W + COL_W;
  localparam int unsigned OUT_SCR_BIT = CHAR_W + COL_W + ROW_W;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd1;

  localparam logic [CHAR_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] BYTE_SPACE = 8'h20;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/text_console_char_writer_top.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: command; tdata: char_code, read_row, read_col
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: cell_char, cursor_col, cursor_row, scrolled
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// A put without scroll reports straight from S_IDLE; a read goes through S_RD (registered screen memory read).
// A scroll runs S_CP and then S_FILL (only S_FILL when rows is 1): the single screen memory
// copies one cell per cycle, then blanks the bottom row.
// After reset the screen memory is blanked one cell per cycle with s_axis_tready low;
// config writes are taken throughout.
// One output beat can wait in m_axis while the next beat is accepted; a second finished
// result parks in a hold register and s_axis_tready stays low until m_axis drains.
module text_console_char_writer_top #(
  parameter int unsigned MAX_COLS = tcw_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col
  input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] cell_char, [14:8] cursor_col, [19:15] cursor_row, [20] scrolled
  output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tcw_pkg::CFG_W-1:0]           cfg_data_i
);
  import tcw_pkg::*;

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CP   = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [LW-1:0]     src_q, src_d;
  logic [LW-1:0]     end_q, end_d;
  logic              pend_q, pend_d;
  logic              rd_ok_q, rd_ok_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  row_width_q;
  logic [ROW_W-1:0]  screen_rows_q;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_cell_q, hold_cell_q;
  logic [COL_W-1:0]  out_col_q, hold_col_q;
  logic [ROW_W-1:0]  out_row_q, hold_row_q;
  logic              out_scr_q, hold_scr_q;

  logic              in_fire, out_free;
  logic              in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_rrow;
  logic [COL_W-1:0]  in_rcol;

  logic [COL_W-1:0]  eff_w, col_c, col_inc, col_n;
  logic [ROW_W-1:0]  eff_r, row_c, row_n;
  logic              is_lf, is_cr, put_store, nl, last_row, do_scroll;
  logic [AW-1:0]     cur_addr, rd_addr;
  logic [LW-1:0]     rows_end, cp_wa;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic              fin_v, fin_scr;
  logic [CHAR_W-1:0] fin_cell;
  logic [COL_W-1:0]  fin_col;
  logic [ROW_W-1:0]  fin_row;

  assign in_cmd  = s_axis_tuser;
  assign in_char = s_axis_tdata[CHAR_W-1:0];
  assign in_rrow = s_axis_tdata[IN_RROW_LSB +: ROW_W];
  assign in_rcol = s_axis_tdata[IN_RCOL_LSB +: COL_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    if (row_width_q == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(row_width_q) > MAX_COLS) begin
      eff_w = COL_W'(MAX_COLS);
    end else begin
      eff_w = row_width_q;
    end
    if (screen_rows_q == '0) begin
      eff_r = ROW_W'(1);
    end else if (32'(screen_rows_q) > MAX_ROWS) begin
      eff_r = ROW_W'(MAX_ROWS);
    end else begin
      eff_r = screen_rows_q;
    end
  end

  always_comb begin
    col_c     = (cur_col_q >= eff_w) ? eff_w - COL_W'(1) : cur_col_q;
    row_c     = (cur_row_q >= eff_r) ? eff_r - ROW_W'(1) : cur_row_q;
    is_lf     = (in_char == BYTE_LF);
    is_cr     = (in_char == BYTE_CR);
    put_store = !is_lf && !is_cr;
    col_inc   = col_c + COL_W'(1);
    nl        = is_lf || (put_store && (col_inc >= eff_w));
    last_row  = (row_c + ROW_W'(1)) >= eff_r;
    do_scroll = nl && last_row;
    col_n     = (nl || is_cr) ? '0 : col_inc;
    if (!nl) begin
      row_n = row_c;
    end else if (last_row) begin
      row_n = eff_r - ROW_W'(1);
    end else begin
      row_n = row_c + ROW_W'(1);
    end
  end

  assign cur_addr = AW'(32'(row_c) * MAX_COLS + 32'(col_c));
  assign rd_addr  = AW'(32'(in_rrow) * MAX_COLS + 32'(in_rcol));
  assign rows_end = LW'(32'(eff_r) * MAX_COLS);
  assign cp_wa    = src_q - LW'(MAX_COLS + 1);

  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    end_d     = end_q;
    pend_d    = 1'b0;
    rd_ok_d   = rd_ok_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    ram_we    = 1'b0;
    ram_waddr = src_q[AW-1:0];
    ram_wdata = BYTE_SPACE;
    ram_re    = 1'b0;
    ram_raddr = src_q[AW-1:0];
    fin_v     = 1'b0;
    fin_cell  = '0;
    fin_col   = cur_col_q;
    fin_row   = cur_row_q;
    fin_scr   = 1'b0;
    case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        if (src_q == LW'(DEPTH - 1)) begin
          state_d = S_IDLE;
          src_d   = '0;
        end else begin
          src_d = src_q + LW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_READ) begin
            ram_re    = 1'b1;
            ram_raddr = rd_addr;
            rd_ok_d   = (32'(in_rrow) < MAX_ROWS) && (32'(in_rcol) < MAX_COLS);
            state_d   = S_RD;
          end else begin
            cur_col_d = col_n;
            cur_row_d = row_n;
            if (put_store) begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = in_char;
            end
            if (do_scroll) begin
              end_d = rows_end;
              if (eff_r == ROW_W'(1)) begin
                state_d = S_FILL;
                src_d   = '0;
              end else begin
                state_d = S_CP;
                src_d   = LW'(MAX_COLS);
              end
            end else begin
              fin_v   = 1'b1;
              fin_col = col_n;
              fin_row = row_n;
            end
          end
        end
      end
      S_RD: begin
        fin_v    = 1'b1;
        fin_cell = rd_ok_q ? ram_rdata : '0;
      end
      S_CP: begin
        if (src_q != end_q) begin
          ram_re = 1'b1;
          src_d  = src_q + LW'(1);
          pend_d = 1'b1;
        end else begin
          state_d = S_FILL;
          src_d   = end_q - LW'(MAX_COLS);
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cp_wa[AW-1:0];
          ram_wdata = ram_rdata;
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (src_q == end_q - LW'(1)) begin
          fin_v   = 1'b1;
          fin_scr = 1'b1;
        end else begin
          src_d = src_q + LW'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin_v) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      src_q         <= '0;
      end_q         <= '0;
      pend_q        <= 1'b0;
      rd_ok_q       <= 1'b0;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      row_width_q   <= COL_W'(80);
      screen_rows_q <= ROW_W'(25);
      out_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      src_q     <= src_d;
      end_q     <= end_d;
      pend_q    <= pend_d;
      rd_ok_q   <= rd_ok_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_WIDTH:   row_width_q   <= cfg_data_i[COL_W-1:0];
          CFG_SCREEN_ROWS: screen_rows_q <= cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == S_HOLD || fin_v) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_HOLD && out_free) begin
      out_cell_q <= hold_cell_q;
      out_col_q  <= hold_col_q;
      out_row_q  <= hold_row_q;
      out_scr_q  <= hold_scr_q;
    end else if (fin_v && out_free) begin
      out_cell_q <= fin_cell;
      out_col_q  <= fin_col;
      out_row_q  <= fin_row;
      out_scr_q  <= fin_scr;
    end
    if (fin_v && !out_free) begin
      hold_cell_q <= fin_cell;
      hold_col_q  <= fin_col;
      hold_row_q  <= fin_row;
      hold_scr_q  <= fin_scr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_SCR_BIT - 1)'(0), out_scr_q, out_row_q,
                          out_col_q, out_cell_q};

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hw/rtl/tcw_chk.sv =====
module tcw_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import tcw_pkg::*;

  logic [2:0] open_q;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_beat && !out_beat) begin
      open_q <= open_q + 3'd1;
    end else if (!in_beat && out_beat) begin
      open_q <= open_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_scroll_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_SCR_BIT] |-> m_axis_tdata[OUT_COL_LSB +: COL_W] == '0)
    else $error("scroll with nonzero cursor column");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input taken during screen clear");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 3'd0)
    else $error("output beat without input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'd2)
    else $error("too many beats in flight");

endmodule

bind text_console_char_writer_top tcw_chk u_tcw_chk (.*);

// ===== bench/text_console_char_writer_top_test.sv =====
`timescale 1ns / 100ps

module text_console_char_writer_top_test;
  import tcw_pkg::*;

  localparam int unsigned COLS = DEF_MAX_COLS;
  localparam int unsigned ROWS = DEF_MAX_ROWS;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned BEATS_PER_PHASE = 225;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 16000000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } cursor_report_t;

  typedef enum logic [1:0] {DO_PUT, DO_READ, DO_CFG} plan_op_e;

  typedef struct packed {
    plan_op_e           op;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_val;
    logic [CHAR_W-1:0]  ch;
    logic [ROW_W-1:0]   rr;
    logic [COL_W-1:0]   rc;
    logic               typed;
    cursor_report_t     want;
  } plan_row_t;

  typedef enum logic [1:0] {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  localparam int unsigned PLAN_LEN = 34;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd0,   1'b1, '{8'h20, 7'd0, 5'd0, 1'b0}},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd31, 7'd127, 1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd25, 7'd0,   1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd80,  1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
    '{DO_PUT,  2'd0, 7'd0, 8'h41, 5'd0,  7'd0,   1'b1, '{8'h00, 7'd1, 5'd0, 1'b0}},
    '{DO_PUT,  2'd0, 7'd0, 8'h00, 5'd31, 7'd127, 1'b1, '{8'h00, 7'd2, 5'd0, 1'b0}},
    '{DO_PUT,  2'd0, 7'd0, 8'hFF, 5'd0,  7'd0,   1'b1, '{8'h00, 7'd3, 5'd0, 1'b0}},
    '{DO_PUT,  2'd0, 7'd0, 8'h0D, 5'd0,  7'd0,   1'b1, '{8'h00, 7'd0, 5'd0, 1'b0}},
    '{DO_READ, 2'd0, 7'd0, 8'hFF, 5'd0,  7'd2,   1'b1, '{8'hFF, 7'd0, 5'd0, 1'b0}},
    '{DO_PUT,  2'd0, 7'd0, 8'h0A, 5'd0,  7'd0,   1'b1, '{8'h00, 7'd0, 5'd1, 1'b0}},
    '{DO_CFG,  CFG_IDX_SPARE2,  7'h7F, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_CFG,  CFG_IDX_SPARE3,  7'h7F, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_CFG,  CFG_SCREEN_ROWS, 7'd2,  8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h0A, 5'd0,  7'd0,   1'b0, '0},
    '{DO_CFG,  CFG_ROW_WIDTH,   7'd3,  8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h78, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h79, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h7A, 5'd0,  7'd0,   1'b0, '0},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd1,   1'b0, '0},
    '{DO_CFG,  CFG_ROW_WIDTH,   7'd0,  8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_CFG,  CFG_SCREEN_ROWS, 7'd0,  8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h71, 5'd0,  7'd0,   1'b0, '0},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd0,   1'b0, '0},
    '{DO_CFG,  CFG_ROW_WIDTH,   7'h7F, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_CFG,  CFG_SCREEN_ROWS, 7'h7F, 8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h31, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h32, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h33, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h34, 5'd0,  7'd0,   1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h35, 5'd0,  7'd0,   1'b0, '0},
    '{DO_CFG,  CFG_ROW_WIDTH,   7'd2,  8'h00, 5'd0, 7'd0, 1'b0, '0},
    '{DO_PUT,  2'd0, 7'd0, 8'h6B, 5'd0,  7'd0,   1'b0, '0},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd3,   1'b0, '0},
    '{DO_READ, 2'd0, 7'd0, 8'h00, 5'd0,  7'd1,   1'b0, '0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [7:0] char_code, [12:8] read_row, [19:13] read_col
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [0] command
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [7:0] cell_char, [14:8] cursor_col, [19:15] cursor_row, [20] scrolled
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;

  // shadow copy of the console state
  logic [CHAR_W-1:0] shadow_screen [COLS*ROWS];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  logic [CFG_W-1:0]  shadow_width;
  logic [ROW_W-1:0]  shadow_rows;

  cursor_report_t pending_reports [$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned beat_count;
  int unsigned read_count;
  int unsigned report_count;
  int unsigned scroll_count;
  int unsigned cfg_writes;
  int unsigned burst_left;
  bit          rx_hold_req;

  text_console_char_writer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned width_eff();
    if (shadow_width < 1) return 1;
    if (shadow_width > COLS) return COLS;
    return shadow_width;
  endfunction

  function automatic int unsigned rows_eff();
    if (shadow_rows < 1) return 1;
    if (shadow_rows > ROWS) return ROWS;
    return shadow_rows;
  endfunction

  function automatic logic line_feed(input int unsigned h);
    shadow_col = '0;
    if (shadow_row + 1 >= h) begin
      for (int i = 0; i < (h - 1) * COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int c = 0; c < COLS; c++) shadow_screen[(h - 1) * COLS + c] = BYTE_SPACE;
      shadow_row = ROW_W'(h - 1);
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic cursor_report_t console_step(input logic cmd, input logic [CHAR_W-1:0] ch,
                                                  input logic [ROW_W-1:0] rr,
                                                  input logic [COL_W-1:0] rc);
    cursor_report_t rep;
    int unsigned    w;
    int unsigned    h;
    rep = '0;
    if (cmd == CMD_READ) begin
      if (rr < ROWS && rc < COLS) rep.cell_char = shadow_screen[rr * COLS + rc];
    end else begin
      w = width_eff();
      h = rows_eff();
      if (shadow_col >= w) shadow_col = COL_W'(w - 1);
      if (shadow_row >= h) shadow_row = ROW_W'(h - 1);
      if (ch == BYTE_LF) begin
        rep.scrolled = line_feed(h);
      end else if (ch == BYTE_CR) begin
        shadow_col = '0;
      end else begin
        shadow_screen[shadow_row * COLS + shadow_col] = ch;
        shadow_col = shadow_col + 1'b1;
        if (shadow_col >= w) rep.scrolled = line_feed(h);
      end
    end
    rep.cursor_col = shadow_col;
    rep.cursor_row = shadow_row;
    return rep;
  endfunction

  task automatic send_beat(input logic cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                           input logic typed, input cursor_report_t want);
    cursor_report_t rep;
    int unsigned    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W - CHAR_W - ROW_W - COL_W){1'b0}}, rc, rr, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    rep = console_step(cmd, ch, rr, rc);
    pending_reports.push_back(typed ? want : rep);
    beat_count++;
    if (cmd == CMD_READ) read_count++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROW_WIDTH:   shadow_width = val;
      CFG_SCREEN_ROWS: shadow_rows  = val[ROW_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cell_char  = m_axis_tdata[CHAR_W-1:0];
      got.cursor_col = m_axis_tdata[OUT_COL_LSB +: COL_W];
      got.cursor_row = m_axis_tdata[OUT_ROW_LSB +: ROW_W];
      got.scrolled   = m_axis_tdata[OUT_SCR_BIT];
      if (pending_reports.size() == 0) begin
        $error("result beat %h with nothing expected", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        report_count++;
        if (want.scrolled) scroll_count++;
        if (got.cell_char !== want.cell_char) begin
          $error("cell_char: expected %h, actual %h", want.cell_char, got.cell_char);
          fail_count++;
        end
        if (got.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, actual %0d", want.cursor_col, got.cursor_col);
          fail_count++;
        end
        if (got.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
          fail_count++;
        end
        if (got.scrolled !== want.scrolled) begin
          $error("scrolled: expected %b, actual %b", want.scrolled, got.scrolled);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    m_axis_tready = 1'b0;
    mode = RX_STREAM;
    mode_left = 0;
    forever begin
      if (rx_hold_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        @(negedge clk_i);
        case (mode)
          RX_STREAM: m_axis_tready <= 1'b1;
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    plan_row_t         prow;
    logic              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    int unsigned       pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUT;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROW_WIDTH;
    cfg_data_i    = '0;
    rx_hold_req   = 1'b0;
    fail_count    = 0;
    beat_count    = 0;
    read_count    = 0;
    report_count  = 0;
    scroll_count  = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    for (int i = 0; i < COLS * ROWS; i++) shadow_screen[i] = BYTE_SPACE;
    shadow_col   = '0;
    shadow_row   = '0;
    shadow_width = CFG_W'(COLS);
    shadow_rows  = ROW_W'(ROWS);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      prow = PLAN[i];
      if (prow.op == DO_CFG) begin
        drain();
        write_cfg(prow.cfg_idx, prow.cfg_val);
      end else begin
        send_beat((prow.op == DO_READ) ? CMD_READ : CMD_PUT, prow.ch, prow.rr, prow.rc,
                  prow.typed, prow.want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_cfg(CFG_ROW_WIDTH, CFG_W'(COLS));
          write_cfg(CFG_SCREEN_ROWS, CFG_W'(ROWS));
        end
        1: begin
          write_cfg(CFG_ROW_WIDTH, 7'd1);
          write_cfg(CFG_SCREEN_ROWS, 7'd1);
        end
        2: begin
          write_cfg(CFG_ROW_WIDTH, 7'h7F);
          write_cfg(CFG_SCREEN_ROWS, 7'h7F);
        end
        3: begin
          write_cfg(CFG_ROW_WIDTH, 7'd0);
          write_cfg(CFG_SCREEN_ROWS, 7'd0);
        end
        default: begin
          write_cfg(CFG_ROW_WIDTH, CFG_W'($urandom_range(0, 127)));
          write_cfg(CFG_SCREEN_ROWS, CFG_W'($urandom_range(0, 9)));
        end
      endcase
      // long receiver hold-off while beats keep coming
      if (ph == 0) rx_hold_req = 1'b1;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (ph == 4 && n == BEATS_PER_PHASE / 2) drain();
        pick = $urandom_range(0, 99);
        ch = CHAR_W'($urandom_range(0, 255));
        rr = ROW_W'($urandom_range(0, 31));
        rc = COL_W'($urandom_range(0, 127));
        cmd = CMD_PUT;
        if (pick < 30) begin
          cmd = CMD_READ;
          if ($urandom_range(0, 9) != 0) begin
            rr = ROW_W'($urandom_range(0, rows_eff() - 1));
            rc = COL_W'($urandom_range(0, width_eff() - 1));
          end
        end else if (pick < 40) begin
          ch = BYTE_LF;
        end else if (pick < 45) begin
          ch = BYTE_CR;
        end
        send_beat(cmd, ch, rr, rc, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Sent %0d beats (%0d reads), checked %0d results with %0d scrolls",
             beat_count, read_count, report_count, scroll_count);
    $display("Register writes: %0d, cycles used: %0d", cfg_writes, cycle_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
